>>> design/quaternion_vector_rotator_macros.svh
// Assertion macros used by the quaternion vector rotator top level.
`ifndef QUATERNION_VECTOR_ROTATOR_MACROS_SVH
`define QUATERNION_VECTOR_ROTATOR_MACROS_SVH

// Overlapping implication, disabled while reset is asserted.
`define QVR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define QVR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/qvr_pkg.sv
// Package of constants and types for the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

    // Default widths and fixed formats.
    localparam int QVR_VECTOR_WIDTH   = 24;
    localparam int QVR_FRACTION_BITS  = 16;
    localparam int QVR_QUAT_FRAC      = 14;
    localparam int QVR_PROD_FRAC      = 2 * QVR_QUAT_FRAC;
    localparam int QVR_OUT_WIDTH      = 29;
    localparam int QVR_QUAT_WIDTH     = 16;

    // Configuration port.
    localparam int QVR_ADDR_WIDTH     = 5;
    localparam int QVR_IDX_WIDTH      = 3;
    localparam int QVR_DATA_WIDTH     = 32;

    // Register indexes.
    localparam logic [QVR_IDX_WIDTH-1:0] REG_MATRIX_SOURCE = 3'd0;
    localparam logic [QVR_IDX_WIDTH-1:0] REG_QUAT_W        = 3'd1;
    localparam logic [QVR_IDX_WIDTH-1:0] REG_QUAT_X        = 3'd2;
    localparam logic [QVR_IDX_WIDTH-1:0] REG_QUAT_Y        = 3'd3;
    localparam logic [QVR_IDX_WIDTH-1:0] REG_QUAT_Z        = 3'd4;

    // Matrix source codes.
    localparam logic [1:0] SRC_IDENTITY = 2'd0;
    localparam logic [1:0] SRC_INER2OBJ = 2'd1;
    localparam logic [1:0] SRC_OBJ2INER = 2'd2;

    // Word commands.
    localparam logic CMD_TRANSPOSE = 1'b0;
    localparam logic CMD_MATRIX    = 1'b1;

    // A register write decoded from the configuration port.
    typedef struct packed {
        logic                       en;
        logic [QVR_IDX_WIDTH-1:0]   idx;
        logic [QVR_QUAT_WIDTH-1:0]  data;
    } t_cfg_wr;

    // Current contents of the configuration registers.
    typedef struct packed {
        logic [1:0]                        source;
        logic signed [QVR_QUAT_WIDTH-1:0]  quat_w;
        logic signed [QVR_QUAT_WIDTH-1:0]  quat_x;
        logic signed [QVR_QUAT_WIDTH-1:0]  quat_y;
        logic signed [QVR_QUAT_WIDTH-1:0]  quat_z;
    } t_cfg_regs;

endpackage

`default_nettype wire

>>> design/qvr_matrix_build.sv
// Configuration registers and the registered rotation matrix built from them.
`default_nettype none

module qvr_matrix_build
    import qvr_pkg::*;
#(
    parameter int FRACTION_BITS = QVR_FRACTION_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire t_cfg_wr                                 i_cfg_wr,
    output t_cfg_regs                                    o_cfg_regs,
    output logic [8:0][FRACTION_BITS+3:0]                o_matrix
);

    localparam int EW = FRACTION_BITS + 4;
    localparam int PW = 35;
    localparam int SH = QVR_PROD_FRAC - FRACTION_BITS;

    localparam logic signed [PW-1:0] ONE_Q = signed'(PW'(1) << QVR_PROD_FRAC);
    localparam logic signed [PW-1:0] ENT_MAX =
        signed'({{(PW-EW+1){1'b0}}, {(EW-1){1'b1}}});
    localparam logic signed [PW-1:0] ENT_MIN =
        signed'({{(PW-EW+1){1'b1}}, {(EW-1){1'b0}}});
    localparam logic [EW-1:0] ENT_ONE = EW'(1) << FRACTION_BITS;
    localparam logic [8:0][EW-1:0] ID_MATRIX =
        {ENT_ONE, {3{EW'(0)}}, ENT_ONE, {3{EW'(0)}}, ENT_ONE};

    t_cfg_regs                 r_regs;
    logic                      r_dirty;
    logic [8:0][EW-1:0]        r_matrix;
    logic [8:0][EW-1:0]        n_matrix;
    logic                      cfg_hit;

    logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
    logic signed [PW-1:0] s_wx, s_wy, s_wz;
    logic                 iner2obj;

    function automatic logic signed [31:0] mul16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        mul16 = 32'(a) * 32'(b);
    endfunction

    function automatic logic [EW-1:0] to_entry(input logic signed [PW-1:0] q);
        logic signed [PW-1:0] v;
        v = q >>> SH;
        if (v > ENT_MAX) begin
            to_entry = ENT_MAX[EW-1:0];
        end else if (v < ENT_MIN) begin
            to_entry = ENT_MIN[EW-1:0];
        end else begin
            to_entry = v[EW-1:0];
        end
    endfunction

    function automatic logic signed [PW-1:0] ext(input logic signed [31:0] p);
        ext = PW'(p);
    endfunction

    // Only writes to one of the five registers start a rebuild.
    assign cfg_hit = i_cfg_wr.en && (i_cfg_wr.idx <= REG_QUAT_Z);

    always_comb begin
        p_xx = mul16(r_regs.quat_x, r_regs.quat_x);
        p_yy = mul16(r_regs.quat_y, r_regs.quat_y);
        p_zz = mul16(r_regs.quat_z, r_regs.quat_z);
        p_xy = mul16(r_regs.quat_x, r_regs.quat_y);
        p_xz = mul16(r_regs.quat_x, r_regs.quat_z);
        p_yz = mul16(r_regs.quat_y, r_regs.quat_z);
        p_wx = mul16(r_regs.quat_w, r_regs.quat_x);
        p_wy = mul16(r_regs.quat_w, r_regs.quat_y);
        p_wz = mul16(r_regs.quat_w, r_regs.quat_z);

        // The object-to-inertial form flips the sign of every w term.
        iner2obj = (r_regs.source == SRC_INER2OBJ);
        s_wx = iner2obj ? ext(p_wx) : -ext(p_wx);
        s_wy = iner2obj ? ext(p_wy) : -ext(p_wy);
        s_wz = iner2obj ? ext(p_wz) : -ext(p_wz);

        if (r_regs.source == SRC_INER2OBJ || r_regs.source == SRC_OBJ2INER) begin
            n_matrix[0] = to_entry(ONE_Q - ((ext(p_yy) + ext(p_zz)) <<< 1));
            n_matrix[1] = to_entry((ext(p_xy) + s_wz) <<< 1);
            n_matrix[2] = to_entry((ext(p_xz) - s_wy) <<< 1);
            n_matrix[3] = to_entry((ext(p_xy) - s_wz) <<< 1);
            n_matrix[4] = to_entry(ONE_Q - ((ext(p_xx) + ext(p_zz)) <<< 1));
            n_matrix[5] = to_entry((ext(p_yz) + s_wx) <<< 1);
            n_matrix[6] = to_entry((ext(p_xz) + s_wy) <<< 1);
            n_matrix[7] = to_entry((ext(p_yz) - s_wx) <<< 1);
            n_matrix[8] = to_entry(ONE_Q - ((ext(p_xx) + ext(p_yy)) <<< 1));
        end else begin
            n_matrix = '0;
            n_matrix[0] = ENT_ONE;
            n_matrix[4] = ENT_ONE;
            n_matrix[8] = ENT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.source <= SRC_IDENTITY;
            r_regs.quat_w <= 16'sd16384;
            r_regs.quat_x <= '0;
            r_regs.quat_y <= '0;
            r_regs.quat_z <= '0;
            r_dirty       <= 1'b0;
            r_matrix      <= ID_MATRIX;
        end else begin
            r_dirty <= cfg_hit;
            if (r_dirty) begin
                r_matrix <= n_matrix;
            end
            if (i_cfg_wr.en) begin
                case (i_cfg_wr.idx)
                    REG_MATRIX_SOURCE: begin
                        r_regs.source <= i_cfg_wr.data[1:0];
                    end
                    REG_QUAT_W: begin
                        r_regs.quat_w <= signed'(i_cfg_wr.data);
                    end
                    REG_QUAT_X: begin
                        r_regs.quat_x <= signed'(i_cfg_wr.data);
                    end
                    REG_QUAT_Y: begin
                        r_regs.quat_y <= signed'(i_cfg_wr.data);
                    end
                    REG_QUAT_Z: begin
                        r_regs.quat_z <= signed'(i_cfg_wr.data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cfg_regs = r_regs;
    assign o_matrix   = r_matrix;

endmodule

`default_nettype wire

>>> design/qvr_vec_mult.sv
// Input and result registers multiplying one vector per cycle, unless output stalls, by the matrix or its transpose.
`default_nettype none

module qvr_vec_mult
    import qvr_pkg::*;
#(
    parameter int VECTOR_WIDTH  = QVR_VECTOR_WIDTH,
    parameter int FRACTION_BITS = QVR_FRACTION_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_cmd,
    input  wire logic [2:0][VECTOR_WIDTH-1:0]         i_vec,
    input  wire logic [8:0][FRACTION_BITS+3:0]        i_matrix,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [2:0][QVR_OUT_WIDTH-1:0]             o_out
);

    localparam int EW  = FRACTION_BITS + 4;
    localparam int PRW = VECTOR_WIDTH + EW;
    localparam int SW  = PRW + 2;
    localparam int OW  = QVR_OUT_WIDTH;
    localparam int XW  = (SW > OW) ? SW : OW;

    logic                           r_v0, r_v1;
    logic                           r_cmd;
    logic [2:0][VECTOR_WIDTH-1:0]   r_vec;
    logic [2:0][2:0][PRW-1:0]       n_prod;
    logic [2:0][OW-1:0]             r_out;
    logic [2:0][OW-1:0]             n_out;
    logic                           s0_ready, s1_ready;
    logic signed [XW-1:0]           sum [3];
    logic signed [XW-1:0]           shifted [3];
    logic [EW-1:0]                  m_sel;

    assign s1_ready = !r_v1 || i_out_ready;
    assign s0_ready = !r_v0 || s1_ready;

    // Row i of the result uses row i of the matrix, or column i for the transpose.
    always_comb begin
        n_prod = '0;
        m_sel  = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m_sel = (r_cmd == CMD_MATRIX) ? i_matrix[i*3+j] : i_matrix[j*3+i];
                n_prod[i][j] = PRW'($signed(PRW'($signed(r_vec[j])))
                                    * $signed(PRW'($signed(m_sel))));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = XW'($signed(n_prod[i][0])) + XW'($signed(n_prod[i][1]))
                   + XW'($signed(n_prod[i][2]));
            shifted[i] = sum[i] >>> FRACTION_BITS;
            n_out[i]   = shifted[i][OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (s0_ready) begin
                r_v0 <= i_in_valid;
            end
            if (s1_ready) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && i_in_valid) begin
            r_cmd <= i_cmd;
            r_vec <= i_vec;
        end
        if (s1_ready && r_v0) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = s0_ready;
    assign o_out_valid = r_v1;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> design/quaternion_vector_rotator.sv
// Top level of the quaternion vector rotator: stream ports, register port and checks.
//
//  Channel   Dir  Handshake              Contents
//  s         in   i_s_tvalid/o_s_tready  tdata: vec_x, vec_y, vec_z; tuser: command
//  m         out  o_m_tvalid/i_m_tready  tdata: out_x, out_y, out_z
//  apb       in   psel/penable/pready    registers matrix_source, quat_w..quat_z
//
//  One word is taken per clock cycle unless the m channel stalls; the datapath has an input
//  register and a result register, and each word passes through both to the m channel.
//  Reset loads the identity matrix at once; no clearing pass is needed.
//  A register write loads the register at its edge and the matrix at the edge after.
//  When i_m_tready is low both registers fill up and o_s_tready falls only once each
//  of them holds a word.
`default_nettype none

module quaternion_vector_rotator
    import qvr_pkg::*;
#(
    parameter int VECTOR_WIDTH  = QVR_VECTOR_WIDTH,
    parameter int FRACTION_BITS = QVR_FRACTION_BITS
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    // Input words.
    input  wire logic                                           i_s_tvalid,
    output logic                                                o_s_tready,
    // tdata, from bit 0 up: vec_x, vec_y, vec_z, zero fill to whole bytes.
    input  wire logic [((3*VECTOR_WIDTH+7)/8)*8-1:0]            i_s_tdata,
    // tuser: command.
    input  wire logic [0:0]                                     i_s_tuser,
    // Result words.
    output logic                                                o_m_tvalid,
    input  wire logic                                           i_m_tready,
    // tdata, from bit 0 up: out_x, out_y, out_z, zero fill to whole bytes.
    output logic [((3*QVR_OUT_WIDTH+7)/8)*8-1:0]                o_m_tdata,
    // Register port.
    input  wire logic                                           psel,
    input  wire logic                                           penable,
    input  wire logic                                           pwrite,
    input  wire logic [QVR_ADDR_WIDTH-1:0]                      paddr,
    input  wire logic [QVR_DATA_WIDTH-1:0]                      pwdata,
    output logic [QVR_DATA_WIDTH-1:0]                           prdata,
    output logic                                                pready
);

`include "quaternion_vector_rotator_macros.svh"

    localparam int EW          = FRACTION_BITS + 4;
    localparam int OUT_TDATA_W = ((3*QVR_OUT_WIDTH+7)/8)*8;

    t_cfg_wr                           cfg_wr;
    t_cfg_regs                         cfg_regs;
    logic [8:0][EW-1:0]                matrix;
    logic [2:0][VECTOR_WIDTH-1:0]      s_vec;
    logic [2:0][QVR_OUT_WIDTH-1:0]     m_out;
    logic [QVR_IDX_WIDTH-1:0]          rd_idx;

    // The register port never waits.
    assign pready = 1'b1;

    // A write lands in the access phase; the byte lane bits of the address are ignored.
    assign cfg_wr.en   = psel && penable && pwrite && pready;
    assign cfg_wr.idx  = paddr[QVR_ADDR_WIDTH-1:2];
    assign cfg_wr.data = pwdata[QVR_QUAT_WIDTH-1:0];

    // Reads return the stored value, the quaternion words sign-extended.
    assign rd_idx = paddr[QVR_ADDR_WIDTH-1:2];
    always_comb begin
        case (rd_idx)
            REG_MATRIX_SOURCE: prdata = QVR_DATA_WIDTH'(cfg_regs.source);
            REG_QUAT_W:        prdata = QVR_DATA_WIDTH'(cfg_regs.quat_w);
            REG_QUAT_X:        prdata = QVR_DATA_WIDTH'(cfg_regs.quat_x);
            REG_QUAT_Y:        prdata = QVR_DATA_WIDTH'(cfg_regs.quat_y);
            REG_QUAT_Z:        prdata = QVR_DATA_WIDTH'(cfg_regs.quat_z);
            default:           prdata = '0;
        endcase
    end

    qvr_matrix_build #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_matrix_build (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .o_cfg_regs (cfg_regs),
        .o_matrix   (matrix)
    );

    // Unpack the three vector components from the low end of tdata.
    assign s_vec = i_s_tdata[3*VECTOR_WIDTH-1:0];

    qvr_vec_mult #(
        .VECTOR_WIDTH  (VECTOR_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_vec_mult (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_cmd       (i_s_tuser[0]),
        .i_vec       (s_vec),
        .i_matrix    (matrix),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out       (m_out)
    );

    // Results packed from bit 0 up with the fill bits at zero.
    assign o_m_tdata = OUT_TDATA_W'(m_out);

    // With the result side empty both registers can move, so a word is always taken.
    `QVR_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "input stalled with empty output")

    // A word accepted with the output side taking words in the next cycle is shown next.
    `QVR_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) ##1 i_m_tready, o_m_tvalid, "accepted word did not reach the output")

    // Reset empties the pipeline.
    `QVR_ASSERT_NEXT_ALWAYS(a_reset_flush, i_clk, !i_rst_n, !o_m_tvalid, "result valid after reset")

endmodule

`default_nettype wire

>>> bench/tb_quaternion_vector_rotator.sv
// Self-checking bench for the quaternion vector rotator: predicted rotations against the result stream.
module tb_quaternion_vector_rotator;
    import qvr_pkg::*;

    // Widths of the stream buses as the block packs them.
    localparam int VW          = QVR_VECTOR_WIDTH;
    localparam int OW          = QVR_OUT_WIDTH;
    localparam int IN_BITS     = ((3 * VW + 7) / 8) * 8;
    localparam int OUT_BITS    = ((3 * OW + 7) / 8) * 8;
    localparam int ENTRY_WIDTH = QVR_FRACTION_BITS + 4;

    // Run shape.
    localparam int PHASES      = 15;
    localparam int PHASE_WORDS = 90;
    localparam int HOLD_PHASE  = 2;
    localparam int LONG_HOLD   = 60;
    localparam int IDLE_LIMIT  = 500;
    localparam int DRAIN       = 8;
    localparam int REPORT_MAX  = 10;

    typedef logic signed [VW-1:0] t_comp;
    typedef logic signed [OW-1:0] t_res;
    typedef logic signed [QVR_QUAT_WIDTH-1:0] t_quat;

    typedef struct packed {
        t_res z;
        t_res y;
        t_res x;
    } t_rotated;

    // Predicts the rotated vectors from its own copy of the registers and matrix, and
    // keeps the rotations still owed by the block in acceptance order.
    class rotation_checker;
        t_cfg_regs                     regs;
        logic signed [ENTRY_WIDTH-1:0] rot_matrix [9];
        t_rotated                      owed_rotations [$];
        int                            mismatches;

        function new();
            regs = '{source: SRC_IDENTITY, quat_w: t_quat'(16384),
                     quat_x: '0, quat_y: '0, quat_z: '0};
            mismatches = 0;
            load_identity();
        endfunction

        function void load_identity();
            for (int i = 0; i < 9; i++) begin
                rot_matrix[i] = (i % 4 == 0) ? ENTRY_WIDTH'(1 << QVR_FRACTION_BITS) : '0;
            end
        endfunction

        // Q4.28 product sum to a Q3.16 entry: floor, then saturate.
        function logic signed [ENTRY_WIDTH-1:0] entry_from_q28(input longint q);
            longint v;
            longint hi;
            longint lo;
            hi = (longint'(1) << (ENTRY_WIDTH - 1)) - 1;
            lo = -hi - 1;
            v  = q >>> (QVR_PROD_FRAC - QVR_FRACTION_BITS);
            if (v > hi) begin
                v = hi;
            end else if (v < lo) begin
                v = lo;
            end
            return v[ENTRY_WIDTH-1:0];
        endfunction

        function void rebuild_matrix();
            longint w;
            longint x;
            longint y;
            longint z;
            longint one_q28;
            longint s;
            if (regs.source != SRC_INER2OBJ && regs.source != SRC_OBJ2INER) begin
                load_identity();
                return;
            end
            w = $signed(regs.quat_w);
            x = $signed(regs.quat_x);
            y = $signed(regs.quat_y);
            z = $signed(regs.quat_z);
            one_q28 = longint'(1) << QVR_PROD_FRAC;
            // The two quaternion forms differ only in the sign of the w terms.
            s = (regs.source == SRC_INER2OBJ) ? 1 : -1;
            rot_matrix[0] = entry_from_q28(one_q28 - 2 * (y * y + z * z));
            rot_matrix[1] = entry_from_q28(2 * (x * y + s * w * z));
            rot_matrix[2] = entry_from_q28(2 * (x * z - s * w * y));
            rot_matrix[3] = entry_from_q28(2 * (x * y - s * w * z));
            rot_matrix[4] = entry_from_q28(one_q28 - 2 * (x * x + z * z));
            rot_matrix[5] = entry_from_q28(2 * (y * z + s * w * x));
            rot_matrix[6] = entry_from_q28(2 * (x * z + s * w * y));
            rot_matrix[7] = entry_from_q28(2 * (y * z - s * w * x));
            rot_matrix[8] = entry_from_q28(one_q28 - 2 * (x * x + y * y));
        endfunction

        // Writes beyond the last register leave both registers and matrix alone.
        function void write_register(input logic [QVR_IDX_WIDTH-1:0] idx,
                                     input logic [QVR_DATA_WIDTH-1:0] value);
            case (idx)
                REG_MATRIX_SOURCE: regs.source = value[1:0];
                REG_QUAT_W:        regs.quat_w = value[QVR_QUAT_WIDTH-1:0];
                REG_QUAT_X:        regs.quat_x = value[QVR_QUAT_WIDTH-1:0];
                REG_QUAT_Y:        regs.quat_y = value[QVR_QUAT_WIDTH-1:0];
                REG_QUAT_Z:        regs.quat_z = value[QVR_QUAT_WIDTH-1:0];
                default:           return;
            endcase
            rebuild_matrix();
        endfunction

        function void note_vector(input logic cmd, input t_comp vx, input t_comp vy,
                                  input t_comp vz);
            longint   comp [3];
            longint   acc;
            t_res     res [3];
            t_rotated r;
            comp[0] = vx;
            comp[1] = vy;
            comp[2] = vz;
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) begin
                    acc += comp[j] * ((cmd == CMD_MATRIX) ? rot_matrix[i * 3 + j]
                                                          : rot_matrix[j * 3 + i]);
                end
                res[i] = t_res'(acc >>> QVR_FRACTION_BITS);
            end
            r.x = res[0];
            r.y = res[1];
            r.z = res[2];
            owed_rotations.push_back(r);
        endfunction

        function void check_rotation(input logic [OUT_BITS-1:0] td);
            t_rotated want;
            t_rotated got;
            got.x = td[OW-1:0];
            got.y = td[2*OW-1:OW];
            got.z = td[3*OW-1:2*OW];
            if (owed_rotations.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result word (%0d, %0d, %0d)", got.x, got.y, got.z);
                end
                return;
            end
            want = owed_rotations.pop_front();
            if (want.x !== got.x || want.y !== got.y || want.z !== got.z) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("rotation differs: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
                             want.x, want.y, want.z, got.x, got.y, got.z);
                end
            end
        endfunction

        function int pending();
            return owed_rotations.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    // From bit 0 up: vec_x, vec_y, vec_z.
    logic [IN_BITS-1:0]        i_s_tdata;
    // command.
    logic [0:0]                i_s_tuser;
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    // From bit 0 up: out_x, out_y, out_z, zero fill.
    logic [OUT_BITS-1:0]       o_m_tdata;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [QVR_ADDR_WIDTH-1:0] paddr;
    logic [QVR_DATA_WIDTH-1:0] pwdata;
    logic [QVR_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    rotation_checker sb;

    // Set by the stimulus to make the result side hold off for a long stretch.
    bit hold_request;
    // When set, the sender offers words back to back.
    bit tx_burst;

    quaternion_vector_rotator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register write through the setup and access cycles; the predictor takes the new
    // value at the same edge as the block does.
    task automatic cfg_write(input logic [QVR_IDX_WIDTH-1:0] idx,
                             input logic [QVR_DATA_WIDTH-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = QVR_ADDR_WIDTH'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_register(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Offers one word after the given gap and returns at the edge that takes it. The
    // valid stays high so that a following word with no gap goes straight on.
    task automatic send_vector(input logic cmd, input t_comp vx, input t_comp vy,
                               input t_comp vz, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {vz, vy, vx};
        i_s_tuser  = cmd;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_vector(cmd, vx, vy, vz);
    endtask

    // Withdraws the valid at once and waits until every owed rotation has come back,
    // so that the registers may be written safely.
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [QVR_DATA_WIDTH-1:0] with_noise(input logic [QVR_DATA_WIDTH-1:0] v,
                                                             input int width);
        logic [QVR_DATA_WIDTH-1:0] noise;
        noise = ($urandom_range(0, 3) == 0) ? QVR_DATA_WIDTH'($urandom) : '0;
        return (noise << width) | v;
    endfunction

    // Writes every register; with noisy set, bits above each field may be filled at random.
    task automatic apply_quaternion(input logic [1:0] src, input t_quat w, input t_quat x,
                                    input t_quat y, input t_quat z, input bit noisy);
        cfg_write(REG_MATRIX_SOURCE, noisy ? with_noise(32'(src), 2) : 32'(src));
        cfg_write(REG_QUAT_W, noisy ? with_noise(32'(w), QVR_QUAT_WIDTH) : 32'(w));
        cfg_write(REG_QUAT_X, noisy ? with_noise(32'(x), QVR_QUAT_WIDTH) : 32'(x));
        cfg_write(REG_QUAT_Y, noisy ? with_noise(32'(y), QVR_QUAT_WIDTH) : 32'(y));
        cfg_write(REG_QUAT_Z, noisy ? with_noise(32'(z), QVR_QUAT_WIDTH) : 32'(z));
    endtask

    // Writes to the unused addresses above the last register, which must change nothing.
    task automatic poke_unused();
        for (int k = int'(REG_QUAT_Z) + 1; k < (1 << QVR_IDX_WIDTH); k++) begin
            cfg_write(QVR_IDX_WIDTH'(k), QVR_DATA_WIDTH'($urandom));
        end
    endtask

    function automatic int tx_gap();
        return tx_burst ? 0 : $urandom_range(0, 8);
    endfunction

    // Components lean towards the extremes and small values, the rest are uniform.
    function automatic t_comp pick_component();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(VW - 1){1'b1}}};
            1:       return {1'b1, {(VW - 1){1'b0}}};
            2:       return t_comp'(int'($urandom_range(0, 64)) - 32);
            default: return t_comp'($urandom);
        endcase
    endfunction

    // Quaternion parts: extremes, zero, values within plus or minus one, near unit length, or anything at all.
    function automatic t_quat pick_quat();
        case ($urandom_range(0, 6))
            0:       return t_quat'(16'sh7fff);
            1:       return t_quat'(16'sh8000);
            2:       return '0;
            3:       return t_quat'(int'($urandom_range(0, 32768)) - 16384);
            4:       return t_quat'(int'($urandom_range(0, 2048)) + 10560);
            default: return t_quat'($urandom);
        endcase
    endfunction

    localparam t_comp CMAX = {1'b0, {(VW - 1){1'b1}}};
    localparam t_comp CMIN = {1'b1, {(VW - 1){1'b0}}};

    // Main stimulus: a directed opening over the reset matrix and the special quaternion
    // cases, then random phases each with its own register setting.
    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_request = 1'b0;
        tx_burst     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The reset matrix is the identity.
        send_vector(CMD_TRANSPOSE, CMAX, CMAX, CMAX, tx_gap());
        send_vector(CMD_MATRIX, CMIN, CMIN, CMIN, tx_gap());
        send_vector(CMD_MATRIX, '0, '0, '0, tx_gap());
        send_vector(CMD_TRANSPOSE, t_comp'(-1), t_comp'(1), t_comp'(-1), tx_gap());

        // A quarter turn about z, in the inertial-to-object form.
        settle();
        apply_quaternion(SRC_INER2OBJ, t_quat'(11585), '0, '0, t_quat'(11585), 1'b0);
        send_vector(CMD_TRANSPOSE, CMAX, CMIN, t_comp'(1), tx_gap());
        send_vector(CMD_MATRIX, CMAX, CMIN, t_comp'(1), tx_gap());

        // Most negative quaternion parts push the entries into saturation.
        settle();
        apply_quaternion(SRC_OBJ2INER, t_quat'(16'sh8000), t_quat'(16'sh8000),
                         t_quat'(16'sh8000), t_quat'(16'sh8000), 1'b0);
        send_vector(CMD_TRANSPOSE, CMAX, CMIN, CMAX, tx_gap());
        send_vector(CMD_MATRIX, CMAX, CMIN, CMAX, tx_gap());
        send_vector(CMD_MATRIX, CMIN, CMIN, CMIN, tx_gap());

        // Most positive parts, other form.
        settle();
        apply_quaternion(SRC_INER2OBJ, t_quat'(16'sh7fff), t_quat'(16'sh7fff),
                         t_quat'(16'sh7fff), t_quat'(16'sh7fff), 1'b0);
        send_vector(CMD_TRANSPOSE, CMAX, CMAX, CMIN, tx_gap());
        send_vector(CMD_MATRIX, CMIN, CMAX, CMAX, tx_gap());

        // The unused source code falls back to the identity.
        settle();
        cfg_write(REG_MATRIX_SOURCE, 32'(2'd3));
        send_vector(CMD_TRANSPOSE, CMAX, t_comp'(-7), CMIN, tx_gap());
        send_vector(CMD_MATRIX, t_comp'(5), CMIN, CMAX, tx_gap());

        // Writes above the last register must leave a real rotation untouched.
        settle();
        apply_quaternion(SRC_OBJ2INER, t_quat'(8192), t_quat'(-8192), t_quat'(8192),
                         t_quat'(8192), 1'b0);
        poke_unused();
        send_vector(CMD_TRANSPOSE, CMAX, CMIN, t_comp'(12345), tx_gap());
        send_vector(CMD_MATRIX, CMAX, CMIN, t_comp'(12345), tx_gap());

        // Random phases. In one of them the result side is held off while words arrive
        // back to back, so the pipeline fills and the input stalls.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            apply_quaternion(2'($urandom_range(0, 3)), pick_quat(), pick_quat(),
                             pick_quat(), pick_quat(), 1'b1);
            if ($urandom_range(0, 3) == 0) begin
                poke_unused();
            end
            tx_burst = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_vector(1'($urandom), pick_component(), pick_component(),
                            pick_component(), tx_gap());
            end
        end

        settle();
        repeat (DRAIN) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: stalls a random number of cycles before each word, with calm stretches
    // in between, and takes the one long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int stall;
        int served;
        bit rx_calm;
        i_m_tready = 1'b0;
        served     = 0;
        rx_calm    = 1'b0;
        wait (i_rst_n);
        forever begin
            if (served % 40 == 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            stall = rx_calm ? 0 : $urandom_range(0, 8);
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_rotation(o_m_tdata);
            served++;
        end
    end

    // Ends the run if nothing moves on any port for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (psel && penable)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
